>>> rtl/core/rrba_pkg.sv
// Shared constants, types and helpers for the round-robin block averager.
package rrba_pkg;

    // Block and slot geometry
    localparam int BLOCK_LENGTH = 50;
    localparam int NUM_SLOTS    = 5;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = $clog2(BLOCK_LENGTH + 1);
    localparam int SUM_W    = 18;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + SLOT_W + SLOT_W + 1 + SAMPLE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Reciprocal for the divide by BLOCK_LENGTH: exact for every SUM_W-bit dividend
    localparam int DIV_SHIFT = 24;
    localparam longint RECIP = ((64'd1 << DIV_SHIFT) + BLOCK_LENGTH - 1) / BLOCK_LENGTH;
    localparam int RECIP_W   = $clog2(RECIP + 1);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [SUM_W-1:0]    sum_t;

    localparam sample_t FULL_SCALE = {SAMPLE_W{1'b1}};
    localparam sample_t ZERO_SCALE = '0;
    localparam count_t  BLOCK_CNT  = COUNT_W'(BLOCK_LENGTH);
    localparam slot_t   LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);

    // Advance a slot index, wrapping after the last slot
    function automatic slot_t next_slot(input slot_t s);
        slot_t r;
        if (s >= LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = s + slot_t'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rrba_avg.sv
// Block average by reciprocal multiply, clamped and reported as full scale minus average.
module rrba_avg (
    input  rrba_pkg::sum_t    sum,
    output rrba_pkg::sample_t average_value
);

    localparam int PROD_W = rrba_pkg::SUM_W + rrba_pkg::RECIP_W;
    localparam logic [rrba_pkg::RECIP_W-1:0] RECIP_VAL = rrba_pkg::RECIP_W'(rrba_pkg::RECIP);

    logic [PROD_W-1:0]       product;
    rrba_pkg::sum_t          quotient;
    rrba_pkg::sample_t       average;

    // Multiply by the scaled reciprocal and drop the fraction bits
    assign product  = PROD_W'(sum) * PROD_W'(RECIP_VAL);
    assign quotient = rrba_pkg::sum_t'(product[PROD_W-1:rrba_pkg::DIV_SHIFT]);

    // Clamp to full scale, then complement
    always_comb
    begin
        if (quotient > rrba_pkg::sum_t'(rrba_pkg::FULL_SCALE))
        begin
            average = rrba_pkg::FULL_SCALE;
        end
        else
        begin
            average = quotient[rrba_pkg::SAMPLE_W-1:0];
        end
    end

    assign average_value = rrba_pkg::FULL_SCALE - average;

endmodule

>>> rtl/core/round_robin_block_averager_top.sv
// Top level of the round-robin block averager: input stage, slot accumulators, result register.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one 12-bit converter sample per
//   transaction. Each transaction advances a slot index over five slots, the first
//   transaction after reset landing in slot 1. Samples of 0 and full scale are
//   rejected; others accumulate into the slot's sum and count, and when a slot
//   collects a full block its average is reported as full scale minus average.
//   Master stream (m_tvalid/m_tready/m_tdata) carries exactly one result per sample.
// Pipeline: a sample passes the input register, then the result register, with the accumulate
//   and reciprocal divide between them, before m_tvalid rises for its result.
// Throughput: one sample per cycle while m_tready stays high; the single read-modify-write
//   of the slot state between the two registers sets that figure.
// Reset: clears the slot index, all counts and sums, and both stage valids.
// Stall: when m_tready is low the result holds; one more sample sits in the input
//   register, after which s_tready drops until the result is taken.
module round_robin_block_averager_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rrba_pkg::IN_DATA_W-1:0]      s_tdata,  // [11:0] sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rrba_pkg::OUT_DATA_W-1:0]     m_tdata   // [0] accepted, [3:1] slot,
                                                          // [6:4] next_channel_slot,
                                                          // [7] average_valid,
                                                          // [19:8] average_value
);

    // Slot state
    rrba_pkg::slot_t   slot_index_reg;
    rrba_pkg::count_t  counts_reg [rrba_pkg::NUM_SLOTS];
    rrba_pkg::sum_t    sums_reg   [rrba_pkg::NUM_SLOTS];

    // Input stage
    logic              s1_valid_reg;
    rrba_pkg::sample_t s1_sample_reg;
    rrba_pkg::slot_t   s1_slot_reg;

    // Result stage
    logic              out_valid_reg;
    logic              accepted_reg;
    rrba_pkg::slot_t   slot_reg;
    rrba_pkg::slot_t   next_ch_reg;
    logic              avg_valid_reg;
    rrba_pkg::sample_t avg_value_reg;

    logic              in_fire;
    logic              s1_move;
    logic              out_free;
    rrba_pkg::slot_t   slot_next;
    rrba_pkg::count_t  count_next;
    rrba_pkg::sum_t    sum_next;
    logic              sample_ok;
    logic              block_done;
    rrba_pkg::sample_t avg_value;

    // Handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_move;
    assign in_fire  = s_tvalid && s_tready;
    assign slot_next = rrba_pkg::next_slot(slot_index_reg);

    // Capture the sample and advance the slot index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            slot_index_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg   <= 1'b1;
                slot_index_reg <= slot_next;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= s_tdata[rrba_pkg::SAMPLE_W-1:0];
            s1_slot_reg   <= slot_next;
        end
    end

    // Accumulate into the selected slot
    assign sample_ok  = (s1_sample_reg != rrba_pkg::ZERO_SCALE) &&
                        (s1_sample_reg != rrba_pkg::FULL_SCALE);
    assign count_next = counts_reg[s1_slot_reg] + rrba_pkg::count_t'(1);
    assign sum_next   = sums_reg[s1_slot_reg] + rrba_pkg::sum_t'(s1_sample_reg);
    assign block_done = (count_next == rrba_pkg::BLOCK_CNT);

    rrba_avg u_avg (
        .sum           (sum_next),
        .average_value (avg_value)
    );

    // Update slot state as the sample moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrba_pkg::NUM_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
                sums_reg[i]   <= '0;
            end
        end
        else if (s1_move && sample_ok)
        begin
            if (block_done)
            begin
                counts_reg[s1_slot_reg] <= '0;
                sums_reg[s1_slot_reg]   <= '0;
            end
            else
            begin
                counts_reg[s1_slot_reg] <= count_next;
                sums_reg[s1_slot_reg]   <= sum_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            accepted_reg  <= sample_ok;
            slot_reg      <= s1_slot_reg;
            next_ch_reg   <= sample_ok ? rrba_pkg::next_slot(s1_slot_reg) : '0;
            avg_valid_reg <= sample_ok && block_done;
            avg_value_reg <= (sample_ok && block_done) ? avg_value : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rrba_pkg::OUT_DATA_W'({avg_value_reg, avg_valid_reg, next_ch_reg,
                                             slot_reg, accepted_reg});

    // Checks
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg <= rrba_pkg::LAST_SLOT)
        else $error("slot index out of range");

    a_avg_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && avg_valid_reg) |-> accepted_reg)
        else $error("average reported for a rejected sample");

    a_avg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && avg_valid_reg) |-> (avg_value_reg != '0))
        else $error("average value below one");

    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> (next_ch_reg == rrba_pkg::next_slot(slot_reg)))
        else $error("next channel slot does not follow slot");

    a_slot_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (slot_reg == $past(s1_slot_reg)))
        else $error("result slot differs from staged slot");

endmodule

>>> tb/round_robin_block_averager_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin block averager: directed table, then random runs.
module round_robin_block_averager_top_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RUNS     = 5;
    localparam int PHASE_ITEMS  = 100;

    // Content of a random run
    typedef enum int {
        FILL_UNIFORM,
        FILL_TOP,
        FILL_REJECTS,
        FILL_BOTTOM,
        FILL_EDGES
    } fill_mode_t;

    // One result transaction, unpacked from m_tdata
    typedef struct packed {
        logic              accepted;
        rrba_pkg::slot_t   slot;
        rrba_pkg::slot_t   next_ch;
        logic              avg_valid;
        rrba_pkg::sample_t avg_value;
    } readout_t;

    typedef struct packed {
        rrba_pkg::sample_t sample;
        logic              typed;
        readout_t          readout;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rrba_pkg::IN_DATA_W-1:0]  s_tdata;   // [11:0] sample
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rrba_pkg::OUT_DATA_W-1:0] m_tdata;   // [0] accepted, [3:1] slot,
                                                // [6:4] next_channel_slot,
                                                // [7] average_valid, [19:8] average_value

    // Predictor state
    rrba_pkg::slot_t  cur_slot;
    rrba_pkg::count_t slot_count [rrba_pkg::NUM_SLOTS];
    rrba_pkg::sum_t   slot_sum [rrba_pkg::NUM_SLOTS];
    readout_t         pending_readouts [$];

    // Idling control
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_left;

    // Run statistics
    int                errors;
    int                cycles;
    int                items_sent;
    int                rejects_sent;
    int                blocks_seen;
    rrba_pkg::sample_t min_avg;
    rrba_pkg::sample_t max_avg;

    stim_row_t  directed_rows [NUM_DIRECTED];
    fill_mode_t run_fill [NUM_RUNS];
    int         run_len [NUM_RUNS];

    round_robin_block_averager_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance the slot, accumulate the sample and work out its readout
    function automatic readout_t accumulate_sample(input rrba_pkg::sample_t smp);
        readout_t         r;
        rrba_pkg::count_t cnt;
        rrba_pkg::sum_t   sum;
        r = '0;
        cur_slot = (cur_slot >= rrba_pkg::slot_t'(rrba_pkg::NUM_SLOTS - 1)) ?
                   rrba_pkg::slot_t'(0) : cur_slot + rrba_pkg::slot_t'(1);
        r.slot = cur_slot;
        if (smp != rrba_pkg::ZERO_SCALE && smp != rrba_pkg::FULL_SCALE)
        begin
            cnt = slot_count[cur_slot] + rrba_pkg::count_t'(1);
            sum = slot_sum[cur_slot] + rrba_pkg::sum_t'(smp);
            r.accepted = 1'b1;
            r.next_ch  = (cur_slot >= rrba_pkg::slot_t'(rrba_pkg::NUM_SLOTS - 1)) ?
                         rrba_pkg::slot_t'(0) : cur_slot + rrba_pkg::slot_t'(1);
            if (cnt == rrba_pkg::count_t'(rrba_pkg::BLOCK_LENGTH))
            begin
                r.avg_valid = 1'b1;
                r.avg_value = rrba_pkg::FULL_SCALE -
                              rrba_pkg::sample_t'(int'(sum) / rrba_pkg::BLOCK_LENGTH);
                slot_count[cur_slot] = '0;
                slot_sum[cur_slot]   = '0;
            end
            else
            begin
                slot_count[cur_slot] = cnt;
                slot_sum[cur_slot]   = sum;
            end
        end
        return r;
    endfunction

    // Draw one sample for the given run content
    function automatic rrba_pkg::sample_t fill_sample(input fill_mode_t mode);
        int pick;
        rrba_pkg::sample_t smp;
        pick = $urandom_range(0, 9);
        case (mode)
            FILL_TOP:    smp = rrba_pkg::FULL_SCALE - rrba_pkg::sample_t'(1);
            FILL_BOTTOM: smp = rrba_pkg::sample_t'(1);
            FILL_REJECTS:
            begin
                if (pick < 2)
                    smp = rrba_pkg::ZERO_SCALE;
                else if (pick < 4)
                    smp = rrba_pkg::FULL_SCALE;
                else
                    smp = rrba_pkg::sample_t'($urandom_range(1, 4094));
            end
            FILL_EDGES:
            begin
                if (pick < 5)
                    smp = rrba_pkg::sample_t'($urandom_range(0, 8));
                else
                    smp = rrba_pkg::sample_t'($urandom_range(4087, 4095));
            end
            default:     smp = rrba_pkg::sample_t'($urandom_range(0, 4095));
        endcase
        return smp;
    endfunction

    function automatic void check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endfunction

    // Offer one sample, hold it until the transaction, then queue its readout
    task automatic send_sample(input rrba_pkg::sample_t smp, input readout_t expv);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rrba_pkg::IN_DATA_W'(smp);
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_readouts.push_back(expv);
        items_sent++;
        if (!expv.accepted)
            rejects_sent++;
    endtask

    // Drop valid and wait for every queued readout to arrive
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest readout
    always @(posedge clk)
    begin
        readout_t expv;
        readout_t act;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.accepted  = m_tdata[0];
            act.slot      = m_tdata[3:1];
            act.next_ch   = m_tdata[6:4];
            act.avg_valid = m_tdata[7];
            act.avg_value = m_tdata[19:8];
            if (pending_readouts.size() == 0)
            begin
                $error("result transaction with no sample outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                expv = pending_readouts.pop_front();
                check_field("accepted", expv.accepted, act.accepted);
                check_field("slot", expv.slot, act.slot);
                check_field("next_channel_slot", expv.next_ch, act.next_ch);
                check_field("average_valid", expv.avg_valid, act.avg_valid);
                check_field("average_value", expv.avg_value, act.avg_value);
                if (expv.avg_valid)
                begin
                    blocks_seen++;
                    if (expv.avg_value < min_avg)
                        min_avg = expv.avg_value;
                    if (expv.avg_value > max_avg)
                        max_avg = expv.avg_value;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycles, pending_readouts.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        readout_t          r;
        rrba_pkg::sample_t smp;
        int                n;
        int                phase;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        errors        = 0;
        cycles        = 0;
        items_sent    = 0;
        rejects_sent  = 0;
        blocks_seen   = 0;
        min_avg       = rrba_pkg::FULL_SCALE;
        max_avg       = '0;
        cur_slot      = '0;
        for (int k = 0; k < rrba_pkg::NUM_SLOTS; k++)
        begin
            slot_count[k] = '0;
            slot_sum[k]   = '0;
        end

        // Directed rows: slot of row i is (i + 1) mod 5 after reset
        directed_rows = '{
            '{12'h000, 1'b1, '{1'b0, 3'd1, 3'd0, 1'b0, 12'd0}},
            '{12'hFFF, 1'b1, '{1'b0, 3'd2, 3'd0, 1'b0, 12'd0}},
            '{12'h001, 1'b1, '{1'b1, 3'd3, 3'd4, 1'b0, 12'd0}},
            '{12'hFFE, 1'b1, '{1'b1, 3'd4, 3'd0, 1'b0, 12'd0}},
            '{12'h800, 1'b1, '{1'b1, 3'd0, 3'd1, 1'b0, 12'd0}},
            '{12'h7FF, 1'b0, '0},
            '{12'h555, 1'b0, '0},
            '{12'hAAA, 1'b0, '0},
            '{12'hFFE, 1'b0, '0},
            '{12'h001, 1'b0, '0},
            '{12'hFFF, 1'b1, '{1'b0, 3'd1, 3'd0, 1'b0, 12'd0}},
            '{12'h000, 1'b1, '{1'b0, 3'd2, 3'd0, 1'b0, 12'd0}},
            '{12'hF0F, 1'b0, '0},
            '{12'h0F0, 1'b0, '0},
            '{12'h123, 1'b0, '0},
            '{12'hEDC, 1'b0, '0},
            '{12'h002, 1'b0, '0},
            '{12'hFFD, 1'b0, '0},
            '{12'h400, 1'b0, '0},
            '{12'hBFF, 1'b0, '0}
        };

        // Random runs: the constant runs are long enough to fill whole blocks
        run_fill = '{FILL_UNIFORM, FILL_TOP, FILL_REJECTS, FILL_BOTTOM, FILL_EDGES};
        run_len  = '{250, 500, 250, 500, 200};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            r = accumulate_sample(directed_rows[i].sample);
            if (directed_rows[i].typed)
                r = directed_rows[i].readout;
            send_sample(directed_rows[i].sample, r);
        end
        drain_results();

        // Random runs, idling setting rotates every hundred items
        n = 0;
        for (int k = 0; k < NUM_RUNS; k++)
        begin
            for (int j = 0; j < run_len[k]; j++)
            begin
                if (n % PHASE_ITEMS == 0)
                begin
                    phase = (n / PHASE_ITEMS) % 4;
                    case (phase)
                        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                        1: begin send_idle_pct = 87; recv_idle_pct = 0;  end
                        2: begin send_idle_pct = 0;  recv_idle_pct = 87; end
                        default: begin send_idle_pct = 37; recv_idle_pct = 37; end
                    endcase
                end
                // Hold off the receiver while samples keep coming
                if (n == 40 || n == 840)
                    hold_req++;
                // Let the block go empty before carrying on
                if (n == 420 || n == 1230)
                    drain_results();
                smp = fill_sample(run_fill[k]);
                r = accumulate_sample(smp);
                send_sample(smp, r);
                n++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d rejected) in %0d cycles across four idling settings.",
                 items_sent, rejects_sent, cycles);
        $display("Checked %0d block averages, reported values from %0d to %0d.",
                 blocks_seen, min_avg, max_avg);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
